// File: sv/brr_pkg.sv
// brr_pkg: shared constants and types of the bilinear remap rectifier
// depends on nothing; used by bilinear_remap_rectify and brr_blend
`default_nettype none

package brr_pkg;

  // fixed field widths of the command and config ports
  localparam int COORD_W    = 20;
  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  // image dimension after reset, before clamping to the store size
  localparam int DIM_RESET = 256;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } cfg_reg_e;

  // control that travels with a sample through the pipeline
  typedef struct packed {
    logic valid;
    logic frame_last;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// File: sv/brr_ram.sv
// brr_ram: generic single-write, dual-read memory with registered read data
// no dependencies
`default_nettype none

module brr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// File: sv/brr_blend.sv
// brr_blend: two-stage bilinear weighting of four neighbor pixels
// depends on brr_pkg (pixel width, pipeline control struct)
`default_nettype none

module brr_blend #(
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  brr_pkg::pipe_ctl_t         ctl_i,
  input  logic [brr_pkg::PIX_W-1:0]  p00_i,
  input  logic [brr_pkg::PIX_W-1:0]  p10_i,
  input  logic [brr_pkg::PIX_W-1:0]  p01_i,
  input  logic [brr_pkg::PIX_W-1:0]  p11_i,
  input  logic [FRAC_BITS-1:0]       du_i,
  input  logic [FRAC_BITS-1:0]       dv_i,
  output brr_pkg::pipe_ctl_t         ctl_o,
  output logic [brr_pkg::PIX_W-1:0]  pixel_o
);

  localparam int WW   = FRAC_BITS + 1;                // weight width, holds 1.0
  localparam int HW   = FRAC_BITS + brr_pkg::PIX_W;   // row blend, below 256 units
  localparam int AccW = 2 * FRAC_BITS + brr_pkg::PIX_W;
  localparam logic [WW-1:0] One = WW'(1) << FRAC_BITS;

  logic [WW-1:0]   wu0, wv0;
  logic [HW:0]     row0_sum, row1_sum;
  logic [HW-1:0]   row0_d, row0_q, row1_d, row1_q;
  logic [WW-1:0]   wv0_q;
  logic [FRAC_BITS-1:0] dv_q;
  brr_pkg::pipe_ctl_t ctl_a_q, ctl_b_q;
  logic [AccW:0]   acc_sum;
  logic [AccW-1:0] acc;
  logic [brr_pkg::PIX_W-1:0] pixel_d, pixel_q;

  // horizontal blend of the top and bottom neighbor pairs
  assign wu0      = One - WW'(du_i);
  assign row0_sum = (HW+1)'(wu0) * (HW+1)'(p00_i) + (HW+1)'(du_i) * (HW+1)'(p10_i);
  assign row1_sum = (HW+1)'(wu0) * (HW+1)'(p01_i) + (HW+1)'(du_i) * (HW+1)'(p11_i);
  assign row0_d   = row0_sum[HW-1:0];
  assign row1_d   = row1_sum[HW-1:0];
  assign wv0      = One - WW'(dv_i);

  always_ff @(posedge clk_i) begin
    row0_q <= row0_d;
    row1_q <= row1_d;
    wv0_q  <= wv0;
    dv_q   <= dv_i;
  end

  // vertical blend, then drop all fraction bits (truncation)
  assign acc_sum = (AccW+1)'(wv0_q) * (AccW+1)'(row0_q)
                 + (AccW+1)'(dv_q)  * (AccW+1)'(row1_q);
  assign acc     = acc_sum[AccW-1:0];
  // the weights sum to one, so the integer part never exceeds 255
  assign pixel_d = acc[AccW-1:2*FRAC_BITS];

  always_ff @(posedge clk_i) begin
    pixel_q <= pixel_d;
  end

  // control bits: valid and frame flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  assign ctl_o   = ctl_b_q;
  assign pixel_o = pixel_q;

  // every sample leaves after passing ctl_a_q and then ctl_b_q
  a_blend_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.valid |-> ##2 ctl_o.valid)
    else $error("blend lost a sample");

  // with zero fractions the result is the top-left pixel
  a_blend_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.valid && du_i == '0 && dv_i == '0) |-> ##2 (pixel_o == $past(p00_i, 2)))
    else $error("blend corner pixel mismatch");

endmodule

`default_nettype wire

// File: sv/bilinear_remap_rectify.sv
// bilinear_remap_rectify: bilinear image remap with border replicate
// depends on brr_pkg, brr_ram (pixel store copies) and brr_blend (weighting)
//
// Usage: one command port, one result strobe, one config write port.
// A command transfers at a rising edge with start_i high and busy_o low;
// busy_o is always low, so a command may be issued in every cycle.
// func_i low loads load_value_i at row-major load_address_i into the store
// and gives no result. func_i high samples at (map_u_i, map_v_i), signed
// fixed point with FRAC_BITS fraction bits, clamped to the image.
// Each sample yields one result: out_valid_o is high for one cycle with
// out_pixel_o and frame_end_o (copy of frame_last_i).
// Throughput is one command per cycle. The pipeline is clamp,
// row-offset multiply, store read, horizontal blend, vertical blend;
// the four neighbor reads come from two store copies with two read ports.
// Results cannot be held off; the receiver must take each one.
// Reset clears the pipeline and sets both dimensions to 256 (limited to the
// store size); store contents are undefined until loaded. Config: cfg_we_i
// writes cfg_wdata_i to register cfg_index_i (0 = image width, 1 = image
// height); the user must write only while no sample is in flight, unchecked.
`default_nettype none

module bilinear_remap_rectify #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command port
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              func_i,
  input  logic [15:0]                       load_address_i,
  input  logic [brr_pkg::PIX_W-1:0]         load_value_i,
  input  logic signed [brr_pkg::COORD_W-1:0] map_u_i,
  input  logic signed [brr_pkg::COORD_W-1:0] map_v_i,
  input  logic                              frame_last_i,
  // result port
  output logic                              out_valid_o,
  output logic [brr_pkg::PIX_W-1:0]         out_pixel_o,
  output logic                              frame_end_o,
  // config port
  input  logic                              cfg_we_i,
  input  logic [brr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [brr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int XIW        = $clog2(MAX_WIDTH);
  localparam int YIW        = $clog2(MAX_HEIGHT);
  localparam int StoreDepth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(StoreDepth);
  localparam int UCW        = XIW + FRAC_BITS;
  localparam int VCW        = YIW + FRAC_BITS;
  localparam int WidthRst   = (brr_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                               : brr_pkg::DIM_RESET;
  localparam int HeightRst  = (brr_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : brr_pkg::DIM_RESET;
  localparam int Latency    = 5;

  // config registers
  logic [XIW:0]   w_q, w_d;
  logic [XIW-1:0] wm1_q, wm1_d;
  logic [YIW-1:0] hm1_q, hm1_d;
  logic [31:0]    cfg_dim, w_eff, h_eff;

  // stage 1: clamp
  logic                  in_xfer;
  logic signed [31:0]    u_sx, v_sx, u_hi, v_hi;
  logic [UCW-1:0]        uc_d, s1_uc_q;
  logic [VCW-1:0]        vc_d, s1_vc_q;
  logic                  s1_smp_q, s1_ld_q, s1_frame_q;
  logic [AW-1:0]         s1_addr_q;
  logic [brr_pkg::PIX_W-1:0] s1_val_q;

  // stage 2: row offsets
  logic [XIW-1:0]        u0, u1, s2_u0_q, s2_u1_q;
  logic [YIW-1:0]        v0, v1;
  logic [AW-1:0]         row0_d, row1_d, s2_row0_q, s2_row1_q;
  logic [FRAC_BITS-1:0]  s2_du_q, s2_dv_q;
  logic                  s2_smp_q, s2_ld_q, s2_frame_q;
  logic [AW-1:0]         s2_addr_q;
  logic [brr_pkg::PIX_W-1:0] s2_val_q;

  // stage 3: store read
  logic [AW-1:0]         a00, a10, a01, a11;
  logic                  ram_we;
  logic [brr_pkg::PIX_W-1:0] p00, p10, p01, p11;
  logic [FRAC_BITS-1:0]  s3_du_q, s3_dv_q;
  brr_pkg::pipe_ctl_t    s3_ctl_q, out_ctl;

  assign busy_o  = 1'b0;
  assign in_xfer = start_i & ~busy_o;

  // clamp a written dimension to [1, max]
  always_comb begin
    cfg_dim = 32'(cfg_wdata_i);
    if (cfg_dim == 32'd0) begin
      w_eff = 32'd1;
      h_eff = 32'd1;
    end else begin
      w_eff = (cfg_dim > 32'(MAX_WIDTH))  ? 32'(MAX_WIDTH)  : cfg_dim;
      h_eff = (cfg_dim > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : cfg_dim;
    end
    w_d   = w_q;
    wm1_d = wm1_q;
    hm1_d = hm1_q;
    if (cfg_we_i) begin
      unique case (brr_pkg::cfg_reg_e'(cfg_index_i))
        brr_pkg::RegImageWidth: begin
          w_d   = (XIW+1)'(w_eff);
          wm1_d = XIW'(w_eff - 32'd1);
        end
        brr_pkg::RegImageHeight: begin
          hm1_d = YIW'(h_eff - 32'd1);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= (XIW+1)'(WidthRst);
      wm1_q <= XIW'(WidthRst - 1);
      hm1_q <= YIW'(HeightRst - 1);
    end else begin
      w_q   <= w_d;
      wm1_q <= wm1_d;
      hm1_q <= hm1_d;
    end
  end

  // stage 1: clamp both coordinates to the image (border replicate)
  assign u_sx = 32'(map_u_i);
  assign v_sx = 32'(map_v_i);
  assign u_hi = {{(32-UCW){1'b0}}, wm1_q, {FRAC_BITS{1'b0}}};
  assign v_hi = {{(32-VCW){1'b0}}, hm1_q, {FRAC_BITS{1'b0}}};

  always_comb begin
    if (u_sx < 0) begin
      uc_d = '0;
    end else if (u_sx > u_hi) begin
      uc_d = UCW'(u_hi);
    end else begin
      uc_d = UCW'(u_sx);
    end
    if (v_sx < 0) begin
      vc_d = '0;
    end else if (v_sx > v_hi) begin
      vc_d = VCW'(v_hi);
    end else begin
      vc_d = VCW'(v_sx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_smp_q <= 1'b0;
      s1_ld_q  <= 1'b0;
    end else begin
      s1_smp_q <= in_xfer & func_i;
      // loads beyond the store are dropped here
      s1_ld_q  <= in_xfer & ~func_i & (32'(load_address_i) < 32'(StoreDepth));
    end
  end

  always_ff @(posedge clk_i) begin
    s1_uc_q    <= uc_d;
    s1_vc_q    <= vc_d;
    s1_frame_q <= frame_last_i;
    s1_addr_q  <= AW'(load_address_i);
    s1_val_q   <= load_value_i;
  end

  // stage 2: neighbor indexes and row offsets
  assign u0     = s1_uc_q[UCW-1:FRAC_BITS];
  assign v0     = s1_vc_q[VCW-1:FRAC_BITS];
  assign u1     = (u0 == wm1_q) ? u0 : u0 + XIW'(1);
  assign v1     = (v0 == hm1_q) ? v0 : v0 + YIW'(1);
  assign row0_d = AW'(v0) * AW'(w_q);
  assign row1_d = AW'(v1) * AW'(w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_smp_q <= 1'b0;
      s2_ld_q  <= 1'b0;
    end else begin
      s2_smp_q <= s1_smp_q;
      s2_ld_q  <= s1_ld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_u0_q    <= u0;
    s2_u1_q    <= u1;
    s2_row0_q  <= row0_d;
    s2_row1_q  <= row1_d;
    s2_du_q    <= s1_uc_q[FRAC_BITS-1:0];
    s2_dv_q    <= s1_vc_q[FRAC_BITS-1:0];
    s2_frame_q <= s1_frame_q;
    s2_addr_q  <= s1_addr_q;
    s2_val_q   <= s1_val_q;
  end

  // stage 3: loads write and samples read at the same stage, so order holds
  assign a00    = s2_row0_q + AW'(s2_u0_q);
  assign a10    = s2_row0_q + AW'(s2_u1_q);
  assign a01    = s2_row1_q + AW'(s2_u0_q);
  assign a11    = s2_row1_q + AW'(s2_u1_q);
  assign ram_we = s2_ld_q;

  // top row copy of the store
  brr_ram #(
    .WIDTH (brr_pkg::PIX_W),
    .DEPTH (StoreDepth)
  ) u_ram_top (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (s2_addr_q),
    .wdata_i   (s2_val_q),
    .raddr_a_i (a00),
    .raddr_b_i (a10),
    .rdata_a_o (p00),
    .rdata_b_o (p10)
  );

  // bottom row copy of the store
  brr_ram #(
    .WIDTH (brr_pkg::PIX_W),
    .DEPTH (StoreDepth)
  ) u_ram_bot (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (s2_addr_q),
    .wdata_i   (s2_val_q),
    .raddr_a_i (a01),
    .raddr_b_i (a11),
    .rdata_a_o (p01),
    .rdata_b_o (p11)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q <= '0;
    end else begin
      s3_ctl_q.valid      <= s2_smp_q;
      s3_ctl_q.frame_last <= s2_frame_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_du_q <= s2_du_q;
    s3_dv_q <= s2_dv_q;
  end

  // stages 4 and 5: weighting
  brr_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s3_ctl_q),
    .p00_i   (p00),
    .p10_i   (p10),
    .p01_i   (p01),
    .p11_i   (p11),
    .du_i    (s3_du_q),
    .dv_i    (s3_dv_q),
    .ctl_o   (out_ctl),
    .pixel_o (out_pixel_o)
  );

  assign out_valid_o = out_ctl.valid;
  assign frame_end_o = out_ctl.frame_last;

  // every sample transfer gives a result
  a_sample_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && func_i) |-> ##Latency out_valid_o)
    else $error("sample without result");

  // no result without a sample transfer, loads give none
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start_i && !busy_o && func_i, Latency))
    else $error("result without sample");

  // frame flag follows its sample
  a_frame_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_end_o == $past(frame_last_i, Latency)))
    else $error("frame flag mismatch");

endmodule

`default_nettype wire

// File: tb/brr_tb_pkg.sv
// brr_tb_pkg: predictor and scoreboard for the bilinear remap rectifier testbench
// depends on brr_pkg for field widths and config register indexes
package brr_tb_pkg;
  import brr_pkg::*;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned StoreDepth = MaxWidth * MaxHeight;

  // command codes carried on func_i
  typedef enum bit {
    FuncLoad   = 1'b0,
    FuncSample = 1'b1
  } func_e;

  // store addresses of the four neighbors and the fraction weights
  typedef struct {
    int unsigned a00;
    int unsigned a10;
    int unsigned a01;
    int unsigned a11;
    int unsigned du;
    int unsigned dv;
  } taps_t;

  typedef struct {
    bit [PIX_W-1:0] pixel;
    bit             frame_end;
  } remap_out_t;

  // zero acts as one, anything above the store size acts as the maximum
  function automatic int unsigned eff_dim(input bit [CFG_DATA_W-1:0] d, input int unsigned lim);
    if (d == 0) return 1;
    if (d > lim) return lim;
    return d;
  endfunction

  // border replicate: clamp to [0, (n-1) * one]
  function automatic int unsigned clamp_axis(input logic signed [COORD_W-1:0] c,
                                             input int unsigned n);
    int signed lim;
    lim = int'((n - 1) << FracBits);
    if (c < 0) return 0;
    if (int'(c) > lim) return lim;
    return int'(c);
  endfunction

  function automatic taps_t neighbor_taps(input logic signed [COORD_W-1:0] u,
                                          input logic signed [COORD_W-1:0] v,
                                          input int unsigned w, input int unsigned h);
    taps_t t;
    int unsigned cu, cv, u0, v0, u1, v1;
    cu = clamp_axis(u, w);
    cv = clamp_axis(v, h);
    u0 = cu >> FracBits;
    v0 = cv >> FracBits;
    t.du = cu & ((1 << FracBits) - 1);
    t.dv = cv & ((1 << FracBits) - 1);
    // right and bottom neighbors stop at the last column and row
    u1 = (u0 + 1 > w - 1) ? w - 1 : u0 + 1;
    v1 = (v0 + 1 > h - 1) ? h - 1 : v0 + 1;
    t.a00 = (v0 * w + u0) % StoreDepth;
    t.a10 = (v0 * w + u1) % StoreDepth;
    t.a01 = (v1 * w + u0) % StoreDepth;
    t.a11 = (v1 * w + u1) % StoreDepth;
    return t;
  endfunction

  class remap_scoreboard;
    bit [PIX_W-1:0]      pixels [StoreDepth];
    bit [CFG_DATA_W-1:0] width_reg;
    bit [CFG_DATA_W-1:0] height_reg;
    remap_out_t          expected_q [$];
    int                  errors;

    function new();
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      errors     = 0;
    endfunction

    function void write_dim(input cfg_reg_e idx, input bit [CFG_DATA_W-1:0] val);
      case (idx)
        RegImageWidth: begin
          width_reg = val;
        end
        RegImageHeight: begin
          height_reg = val;
        end
        default: begin
        end
      endcase
    endfunction

    // weighted sum with 2*FracBits fraction bits, truncated and limited
    function bit [PIX_W-1:0] interpolate(input logic signed [COORD_W-1:0] u,
                                         input logic signed [COORD_W-1:0] v);
      taps_t t;
      longint unsigned one, acc;
      t = neighbor_taps(u, v, eff_dim(width_reg, MaxWidth), eff_dim(height_reg, MaxHeight));
      one = longint'(1) << FracBits;
      acc = (one - t.du) * (one - t.dv) * pixels[t.a00]
          + t.du * (one - t.dv) * pixels[t.a10]
          + (one - t.du) * t.dv * pixels[t.a01]
          + t.du * t.dv * pixels[t.a11];
      acc = acc >> (2 * FracBits);
      if (acc > 255) acc = 255;
      return acc[PIX_W-1:0];
    endfunction

    // one accepted command transfer: loads update the store, samples queue a result
    function void note_command(input func_e f, input bit [15:0] addr,
                               input bit [PIX_W-1:0] value,
                               input logic signed [COORD_W-1:0] u,
                               input logic signed [COORD_W-1:0] v, input bit last);
      remap_out_t r;
      if (f == FuncLoad) begin
        pixels[addr] = value;
      end else begin
        r.pixel     = interpolate(u, v);
        r.frame_end = last;
        expected_q.push_back(r);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(input logic [PIX_W-1:0] pixel, input logic frame_end);
      remap_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending, pixel %0d", pixel));
      end else begin
        want = expected_q.pop_front();
        if (pixel !== want.pixel)
          report($sformatf("out_pixel got %0d want %0d", pixel, want.pixel));
        if (frame_end !== want.frame_end)
          report($sformatf("frame_end got %b want %b", frame_end, want.frame_end));
      end
    endtask
  endclass

endpackage

// File: tb/bilinear_remap_rectify_tb.sv
// bilinear_remap_rectify_tb: directed and random loads and samples over several image sizes
// depends on brr_pkg, brr_tb_pkg and the bilinear_remap_rectify rtl
module bilinear_remap_rectify_tb;
  import brr_pkg::*;
  import brr_tb_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int PhaseItems   = 170;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic                        func_i;
  logic [15:0]                 load_address_i;
  logic [PIX_W-1:0]            load_value_i;
  logic signed [COORD_W-1:0]   map_u_i;
  logic signed [COORD_W-1:0]   map_v_i;
  logic                        frame_last_i;
  logic                        out_valid_o;
  logic [PIX_W-1:0]            out_pixel_o;
  logic                        frame_end_o;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [CFG_DATA_W-1:0]       cfg_wdata_i;

  remap_scoreboard sb;
  bit              loaded [StoreDepth];
  int unsigned     cur_w = MaxWidth;
  int unsigned     cur_h = MaxHeight;
  int unsigned     base_x, base_y;
  int              burst_left = 0;
  int              items_sent = 0;
  int              cycle_count;

  bilinear_remap_rectify #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight),
    .FRAC_BITS (FracBits)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .load_address_i(load_address_i),
    .load_value_i  (load_value_i),
    .map_u_i       (map_u_i),
    .map_v_i       (map_v_i),
    .frame_last_i  (frame_last_i),
    .out_valid_o   (out_valid_o),
    .out_pixel_o   (out_pixel_o),
    .frame_end_o   (frame_end_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // monitor: config writes, command transfers and results, all at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i)
        sb.write_dim(cfg_reg_e'(cfg_index_i), cfg_wdata_i);
      if (start_i && busy_o === 1'b0)
        sb.note_command(func_e'(func_i), load_address_i, load_value_i, map_u_i, map_v_i,
                        frame_last_i);
      if (out_valid_o !== 1'b0)
        sb.check_result(out_pixel_o, frame_end_o);
    end
  end

  // one command transfer; a new burst may open with an idle gap
  task automatic drive_command(input func_e f, input bit [15:0] addr,
                               input bit [PIX_W-1:0] value,
                               input logic signed [COORD_W-1:0] u,
                               input logic signed [COORD_W-1:0] v, input bit last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0)
        repeat ($urandom_range(1, 7)) begin
          @(negedge clk_i);
          start_i <= 1'b0;
        end
    end
    burst_left--;
    @(negedge clk_i);
    start_i        <= 1'b1;
    func_i         <= f;
    load_address_i <= addr;
    load_value_i   <= value;
    map_u_i        <= u;
    map_v_i        <= v;
    frame_last_i   <= last;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    items_sent++;
  endtask

  // sample fields of a load carry noise
  task automatic load_pixel(input bit [15:0] addr, input bit [PIX_W-1:0] value);
    loaded[addr] = 1'b1;
    drive_command(FuncLoad, addr, value, $urandom, $urandom, $urandom);
  endtask

  // load any neighbor not yet written, then sample
  task automatic sample_at(input logic signed [COORD_W-1:0] u,
                           input logic signed [COORD_W-1:0] v, input bit last);
    taps_t       t;
    int unsigned a [4];
    t = neighbor_taps(u, v, cur_w, cur_h);
    a = '{t.a00, t.a10, t.a01, t.a11};
    foreach (a[i])
      if (!loaded[a[i]]) load_pixel(a[i], $urandom);
    drive_command(FuncSample, $urandom, $urandom, u, v, last);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input bit [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == RegImageWidth) cur_w = eff_dim(val, MaxWidth);
    else cur_h = eff_dim(val, MaxHeight);
  endtask

  // drain all results, then let in-flight loads retire
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one axis: full range, edge values, around the image, or near the current window
  function automatic logic signed [COORD_W-1:0] random_axis(input int unsigned n,
                                                            input int unsigned base);
    logic signed [COORD_W-1:0] r;
    int                        mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      r = $urandom;
    end else if (mode == 1) begin
      case ($urandom_range(0, 5))
        0: r = 20'sh80000;
        1: r = 20'sh7FFFF;
        2: r = '0;
        3: r = (n - 1) << FracBits;
        4: r = ((n - 1) << FracBits) + 1;
        default: r = -1;
      endcase
    end else if (mode <= 4) begin
      r = $urandom_range(0, (n + 2) << FracBits) - (1 << FracBits);
    end else begin
      r = ((base + $urandom_range(0, 3)) << FracBits) | $urandom_range(0, (1 << FracBits) - 1);
    end
    return r;
  endfunction

  task automatic rebase();
    base_x = $urandom_range(0, cur_w - 1);
    base_y = $urandom_range(0, cur_h - 1);
  endtask

  task automatic random_step();
    int unsigned addr;
    if ($urandom_range(0, 31) == 0) rebase();
    if ($urandom_range(0, 6) == 0) begin
      // reload near the window so samples see fresh data, or anywhere
      if ($urandom_range(0, 1) == 0)
        addr = ((base_y + $urandom_range(0, 3)) % cur_h) * cur_w
             + (base_x + $urandom_range(0, 3)) % cur_w;
      else
        addr = $urandom_range(0, StoreDepth - 1);
      load_pixel(addr, $urandom);
    end else begin
      sample_at(random_axis(cur_w, base_x), random_axis(cur_h, base_y),
                $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    int unsigned phase_w [10];
    int unsigned phase_h [10];
    int          goal;
    sb             = new();
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    func_i         = FuncLoad;
    load_address_i = '0;
    load_value_i   = '0;
    map_u_i        = '0;
    map_v_i        = '0;
    frame_last_i   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = RegImageWidth;
    cfg_wdata_i    = '0;
    phase_w = '{0, 1, 2, 511, 257, 256, 17, 1, 100, 0};
    phase_h = '{0, 256, 3, 2, 511, 1, 256, 1, 63, 0};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: full-scale corner, coordinate extremes, edges, a half-way blend
    load_pixel(16'd0, 8'hFF);
    load_pixel(16'd1, 8'hFF);
    load_pixel(16'd256, 8'hFF);
    load_pixel(16'd257, 8'hFF);
    sample_at(20'sh00080, 20'sh00080, 1'b0);
    load_pixel(16'hFFFF, 8'hFF);
    load_pixel(16'd2, 8'h00);
    load_pixel(16'd258, 8'h00);
    sample_at(20'sh80000, 20'sh80000, 1'b0);
    sample_at(20'sh7FFFF, 20'sh7FFFF, 1'b1);
    sample_at(20'sh00180, 20'sh00000, 1'b0);
    sample_at(20'sh00000, 20'sh00000, 1'b0);
    sample_at(20'sh0FF80, 20'sh0007F, 1'b0);
    sample_at(20'sh000FF, 20'sh00001, 1'b1);
    sample_at(20'sh00000, 20'sh0FFFF, 1'b0);
    load_pixel(16'd1, 8'h5A);
    sample_at(20'sh00040, 20'sh000C0, 1'b0);

    // random at reset dimensions, then one phase per dimension setting
    rebase();
    goal = items_sent + PhaseItems;
    while (items_sent < goal) random_step();
    foreach (phase_w[p]) begin
      settle();
      if (p >= 9) begin
        phase_w[p] = $urandom_range(0, 511);
        phase_h[p] = $urandom_range(0, 511);
      end
      write_reg(RegImageWidth, phase_w[p]);
      write_reg(RegImageHeight, phase_h[p]);
      rebase();
      goal = items_sent + PhaseItems;
      while (items_sent < goal) random_step();
    end

    settle();
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
sv/brr_pkg.sv
sv/brr_ram.sv
sv/brr_blend.sv
sv/bilinear_remap_rectify.sv
tb/brr_tb_pkg.sv
tb/bilinear_remap_rectify_tb.sv
